### rtl/e2r_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2r_pkg
// Types, widths, constants and arithmetic helpers shared by the Euler angle
// to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ANGLE_W   = 16;
  localparam int FIELD_W   = 16;

  // sine and cosine values in Q1.FRAC_BITS, range -1.0 .. +1.0 inclusive
  localparam int TRIG_W = FRAC_BITS + 2;
  localparam int PROD_W = 2 * TRIG_W;
  localparam int SUM_W  = PROD_W + 1;

  // rotator: 32-bit binary angle, Q2.30 vectors with headroom
  localparam int BAM_W        = 32;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_ITERS = 30;
  localparam int ITER_IDX_W   = $clog2(CORDIC_ITERS);
  localparam int TRIG_SHIFT   = CORDIC_FRAC - FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

  // pipeline depth: input stage, one stage per rotation, round, sign fix-up,
  // then five stages of matrix arithmetic ending in the result register
  localparam int CORDIC_LAT = CORDIC_ITERS + 3;
  localparam int MATRIX_LAT = 5;
  localparam int LATENCY    = CORDIC_LAT + MATRIX_LAT;

  localparam longint ONE_VAL   = longint'(1) << FRAC_BITS;
  localparam longint FIELD_MAX = (longint'(1) << (FIELD_W - 1)) - 1;
  localparam longint FIELD_MIN = -FIELD_MAX - 1;
  localparam logic signed [SUM_W-1:0] ENTRY_HI =
    SUM_W'((ONE_VAL < FIELD_MAX) ? ONE_VAL : FIELD_MAX);
  localparam logic signed [SUM_W-1:0] ENTRY_LO =
    SUM_W'((-ONE_VAL > FIELD_MIN) ? -ONE_VAL : FIELD_MIN);
  localparam logic signed [SUM_W-1:0] RND_HALF    = SUM_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] RND_HALF_M1 = RND_HALF - SUM_W'(1);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] xb_x;
    logic signed [FIELD_W-1:0] xb_y;
    logic signed [FIELD_W-1:0] xb_z;
    logic signed [FIELD_W-1:0] yb_x;
    logic signed [FIELD_W-1:0] yb_y;
    logic signed [FIELD_W-1:0] yb_z;
    logic signed [FIELD_W-1:0] zb_x;
    logic signed [FIELD_W-1:0] zb_y;
    logic signed [FIELD_W-1:0] zb_z;
  } matrix_t;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [ITER_IDX_W-1:0] idx);
    logic [BAM_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051D;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2E;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000028;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000002;
      5'd29:   a = 32'h00000001;
      default: a = '0;
    endcase
    return CORDIC_W'(a);
  endfunction

  // divide by 2^FRAC_BITS, round to nearest, ties away from zero
  function automatic logic signed [SUM_W-1:0] rnd_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] adj;
    adj = v[SUM_W-1] ? RND_HALF_M1 : RND_HALF;
    return (v + adj) >>> FRAC_BITS;
  endfunction

  // clamp to +/-1.0 and to the range of the output field
  function automatic logic signed [FIELD_W-1:0] sat_entry(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > ENTRY_HI) begin
      c = ENTRY_HI;
    end else if (v < ENTRY_LO) begin
      c = ENTRY_LO;
    end else begin
      c = v;
    end
    return c[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/e2r_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined rotation-mode CORDIC: sine and cosine of one binary angle,
// rounded and clamped to Q1.FRAC_BITS. One rotation per register stage.
// ----------------------------------------------------------------------------
module e2r_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [e2r_pkg::ANGLE_W-1:0]   angle,
  output logic signed [e2r_pkg::TRIG_W-1:0]         sin_val,
  output logic signed [e2r_pkg::TRIG_W-1:0]         cos_val
);

  localparam int CW    = e2r_pkg::CORDIC_W;
  localparam int NIT   = e2r_pkg::CORDIC_ITERS;
  localparam int SHIFT = e2r_pkg::TRIG_SHIFT;
  localparam logic signed [CW-1:0] ONE_C   = CW'(e2r_pkg::ONE_VAL);
  localparam logic signed [CW-1:0] HALF    = CW'((longint'(1) << SHIFT) >> 1);
  localparam logic signed [CW-1:0] HALF_M1 = HALF - CW'(1);

  function automatic logic signed [e2r_pkg::TRIG_W-1:0] round_trig(
    input logic signed [CW-1:0] v
  );
    logic signed [CW-1:0] adj;
    logic signed [CW-1:0] r;
    adj = v[CW-1] ? HALF_M1 : HALF;
    if (SHIFT == 0) begin
      r = v;
    end else begin
      r = (v + adj) >>> SHIFT;
    end
    if (r > ONE_C) begin
      r = ONE_C;
    end else if (r < -ONE_C) begin
      r = -ONE_C;
    end
    return r[e2r_pkg::TRIG_W-1:0];
  endfunction

  logic signed [CW-1:0] x_pipe [0:NIT];
  logic signed [CW-1:0] y_pipe [0:NIT];
  logic signed [CW-1:0] z_pipe [0:NIT];
  logic [NIT:0]         flip_pipe;

  logic [e2r_pkg::BAM_W-1:0] bam;
  logic                      flip_in;
  logic [e2r_pkg::BAM_W-1:0] bam_fold;

  // angles in the left half-plane are folded by pi and the results negated
  assign bam      = {angle, {(e2r_pkg::BAM_W - e2r_pkg::ANGLE_W){1'b0}}};
  assign flip_in  = bam[e2r_pkg::BAM_W-1] ^ bam[e2r_pkg::BAM_W-2];
  assign bam_fold = {bam[e2r_pkg::BAM_W-1] ^ flip_in, bam[e2r_pkg::BAM_W-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      x_pipe[0]    <= e2r_pkg::CORDIC_GAIN;
      y_pipe[0]    <= '0;
      z_pipe[0]    <= CW'(signed'(bam_fold));
      flip_pipe[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_iter
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] da;

    assign dx = y_pipe[i] >>> i;
    assign dy = x_pipe[i] >>> i;
    assign da = e2r_pkg::atan_entry(e2r_pkg::ITER_IDX_W'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_pipe[i][CW-1]) begin
          x_pipe[i+1] <= x_pipe[i] - dx;
          y_pipe[i+1] <= y_pipe[i] + dy;
          z_pipe[i+1] <= z_pipe[i] - da;
        end else begin
          x_pipe[i+1] <= x_pipe[i] + dx;
          y_pipe[i+1] <= y_pipe[i] - dy;
          z_pipe[i+1] <= z_pipe[i] + da;
        end
        flip_pipe[i+1] <= flip_pipe[i];
      end
    end
  end

  logic signed [e2r_pkg::TRIG_W-1:0] cos_r;
  logic signed [e2r_pkg::TRIG_W-1:0] sin_r;
  logic                              flip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r   <= round_trig(x_pipe[NIT]);
      sin_r   <= round_trig(y_pipe[NIT]);
      flip_r  <= flip_pipe[NIT];
      cos_val <= flip_r ? -cos_r : cos_r;
      sin_val <= flip_r ? -sin_r : sin_r;
    end
  end

endmodule
`default_nettype wire

### rtl/euler_to_rotation_matrix_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_unit
// Roll, pitch and yaw binary angles in, Z-Y-X rotation matrix out as three
// Q1.14 basis vectors.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while no result waits unaccepted in the
// output register. Each request passes through the three parallel CORDIC
// pipelines, one rotation per stage, then through products, rounding, sums
// and saturation. The whole pipeline advances together: it holds while a
// result sits in the output register unaccepted, and empty slots in the
// pipeline are not squeezed out. There is no state between requests.
module euler_to_rotation_matrix_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             angles_valid,
  output logic                  angles_ready,
  input  wire e2r_pkg::angles_t angles,
  output logic                  matrix_valid,
  input  wire logic             matrix_ready,
  output e2r_pkg::matrix_t      matrix
);

  localparam int TW  = e2r_pkg::TRIG_W;
  localparam int PW  = e2r_pkg::PROD_W;
  localparam int SW  = e2r_pkg::SUM_W;
  localparam int LAT = e2r_pkg::LATENCY;

  logic           advance;
  logic [LAT-1:0] vld;

  assign advance      = !vld[LAT-1] || matrix_ready;
  assign angles_ready = advance;
  assign matrix_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-2:0], angles_valid};
    end
  end

  logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;

  e2r_cordic u_roll (
    .clk(clk), .en(advance), .angle(angles.roll_angle), .sin_val(sr), .cos_val(cr)
  );
  e2r_cordic u_pitch (
    .clk(clk), .en(advance), .angle(angles.pitch_angle), .sin_val(sp), .cos_val(cp)
  );
  e2r_cordic u_yaw (
    .clk(clk), .en(advance), .angle(angles.yaw_angle), .sin_val(sy), .cos_val(cy)
  );

  // stage 1: products of pairs
  logic signed [PW-1:0] p_cpcy, p_cpsy, p_srcp, p_crcp, p_srsp, p_crsp;
  logic signed [PW-1:0] p_crsy, p_srsy, p_crcy, p_srcy;
  logic signed [TW-1:0] d1_sp, d1_cy, d1_sy;

  // stage 2: rounded pairs, raw cross terms kept exact
  logic signed [TW-1:0] e2_xbx, e2_ybx, e2_zby, e2_zbz, t2_srsp, t2_crsp;
  logic signed [PW-1:0] q_crsy, q_srsy, q_crcy, q_srcy;
  logic signed [TW-1:0] d2_sp, d2_cy, d2_sy;

  // stage 3: three-factor products
  logic signed [PW-1:0] m_tcy, m_tsy, m_ucy, m_usy;
  logic signed [PW-1:0] r_crsy, r_srsy, r_crcy, r_srcy;
  logic signed [TW-1:0] e3_xbx, e3_ybx, e3_zby, e3_zbz, d3_sp;

  // stage 4: exact sums ahead of the final rounding
  logic signed [SW-1:0] s_xby, s_yby, s_xbz, s_ybz;
  logic signed [TW-1:0] e4_xbx, e4_ybx, e4_zby, e4_zbz, d4_sp;

  always_ff @(posedge clk) begin
    if (advance) begin
      p_cpcy <= cp * cy;
      p_cpsy <= cp * sy;
      p_srcp <= sr * cp;
      p_crcp <= cr * cp;
      p_srsp <= sr * sp;
      p_crsp <= cr * sp;
      p_crsy <= cr * sy;
      p_srsy <= sr * sy;
      p_crcy <= cr * cy;
      p_srcy <= sr * cy;
      d1_sp  <= sp;
      d1_cy  <= cy;
      d1_sy  <= sy;

      e2_xbx  <= TW'(e2r_pkg::rnd_sum(SW'(p_cpcy)));
      e2_ybx  <= TW'(e2r_pkg::rnd_sum(SW'(p_cpsy)));
      e2_zby  <= TW'(e2r_pkg::rnd_sum(SW'(p_srcp)));
      e2_zbz  <= TW'(e2r_pkg::rnd_sum(SW'(p_crcp)));
      t2_srsp <= TW'(e2r_pkg::rnd_sum(SW'(p_srsp)));
      t2_crsp <= TW'(e2r_pkg::rnd_sum(SW'(p_crsp)));
      q_crsy  <= p_crsy;
      q_srsy  <= p_srsy;
      q_crcy  <= p_crcy;
      q_srcy  <= p_srcy;
      d2_sp   <= d1_sp;
      d2_cy   <= d1_cy;
      d2_sy   <= d1_sy;

      m_tcy  <= t2_srsp * d2_cy;
      m_tsy  <= t2_srsp * d2_sy;
      m_ucy  <= t2_crsp * d2_cy;
      m_usy  <= t2_crsp * d2_sy;
      r_crsy <= q_crsy;
      r_srsy <= q_srsy;
      r_crcy <= q_crcy;
      r_srcy <= q_srcy;
      e3_xbx <= e2_xbx;
      e3_ybx <= e2_ybx;
      e3_zby <= e2_zby;
      e3_zbz <= e2_zbz;
      d3_sp  <= d2_sp;

      s_xby  <= SW'(m_tcy) - SW'(r_crsy);
      s_yby  <= SW'(m_tsy) + SW'(r_crcy);
      s_xbz  <= SW'(m_ucy) + SW'(r_srsy);
      s_ybz  <= SW'(m_usy) - SW'(r_srcy);
      e4_xbx <= e3_xbx;
      e4_ybx <= e3_ybx;
      e4_zby <= e3_zby;
      e4_zbz <= e3_zbz;
      d4_sp  <= d3_sp;

      matrix.xb_x <= e2r_pkg::sat_entry(SW'(e4_xbx));
      matrix.xb_y <= e2r_pkg::sat_entry(e2r_pkg::rnd_sum(s_xby));
      matrix.xb_z <= e2r_pkg::sat_entry(e2r_pkg::rnd_sum(s_xbz));
      matrix.yb_x <= e2r_pkg::sat_entry(SW'(e4_ybx));
      matrix.yb_y <= e2r_pkg::sat_entry(e2r_pkg::rnd_sum(s_yby));
      matrix.yb_z <= e2r_pkg::sat_entry(e2r_pkg::rnd_sum(s_ybz));
      matrix.zb_x <= e2r_pkg::sat_entry(-SW'(d4_sp));
      matrix.zb_y <= e2r_pkg::sat_entry(SW'(e4_zby));
      matrix.zb_z <= e2r_pkg::sat_entry(SW'(e4_zbz));
    end
  end

  // hold every slot while the result waits
  assert property (@(posedge clk) disable iff (rst) !angles_ready |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  // an accepted request must occupy the first slot
  assert property (@(posedge clk) disable iff (rst)
    angles_valid && angles_ready |=> vld[0])
    else $error("accepted request lost at pipeline entry");

  // diagonal entries stay within the saturation limits
  assert property (@(posedge clk) disable iff (rst)
    matrix_valid |->
      SW'(matrix.xb_x) <= e2r_pkg::ENTRY_HI && SW'(matrix.xb_x) >= e2r_pkg::ENTRY_LO &&
      SW'(matrix.yb_y) <= e2r_pkg::ENTRY_HI && SW'(matrix.yb_y) >= e2r_pkg::ENTRY_LO &&
      SW'(matrix.zb_z) <= e2r_pkg::ENTRY_HI && SW'(matrix.zb_z) >= e2r_pkg::ENTRY_LO)
    else $error("matrix entry beyond unit range");

endmodule
`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams roll/pitch/yaw requests through euler_to_rotation_matrix_unit and
// checks every rotation matrix against a bit-exact CORDIC based predictor,
// with bursty input, a patterned output stall and two long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RANDOM_REQUESTS = 1150;
  localparam int  HOLD_OFF_CYCLES = 160;
  localparam longint ROTATOR_GAIN = 652032874;
  localparam longint ATAN_TAB [0:29] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             angles_valid = 1'b0;
  logic             angles_ready;
  e2r_pkg::angles_t angles = '0;
  logic             matrix_valid;
  logic             matrix_ready = 1'b0;
  e2r_pkg::matrix_t matrix;

  e2r_pkg::angles_t angles_pending_q[$];
  e2r_pkg::matrix_t matrix_expected_q[$];

  int errors = 0;
  int requests_accepted = 0;
  int matrices_checked = 0;
  int input_stall_cycles = 0;

  euler_to_rotation_matrix_unit dut (
    .clk          (clk),
    .rst          (rst),
    .angles_valid (angles_valid),
    .angles_ready (angles_ready),
    .angles       (angles),
    .matrix_valid (matrix_valid),
    .matrix_ready (matrix_ready),
    .matrix       (matrix)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // divide by 2^s, nearest, ties away from zero
  function automatic longint round_away(input longint v, input int s);
    longint half;
    if (s <= 0) begin
      return v;
    end
    half = longint'(1) << (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint clamp_unit(input longint v);
    longint one;
    one = longint'(1) << e2r_pkg::FRAC_BITS;
    if (v > one) begin
      v = one;
    end
    if (v < -one) begin
      v = -one;
    end
    return v;
  endfunction

  function automatic logic signed [e2r_pkg::FIELD_W-1:0] to_entry(input longint v);
    longint c;
    c = clamp_unit(v);
    if (c > 32767) begin
      c = 32767;
    end
    if (c < -32768) begin
      c = -32768;
    end
    return c[e2r_pkg::FIELD_W-1:0];
  endfunction

  function automatic void angle_sin_cos(input logic signed [e2r_pkg::ANGLE_W-1:0] ang,
                                        output longint s, output longint c);
    bit [31:0] a;
    bit [31:0] probe;
    bit        flip;
    longint    x, y, z, dx, dy;
    a     = {ang, 16'h0000};
    probe = a + 32'h40000000;
    flip  = probe[31];
    // fold the left half-plane onto the right one, negate at the end
    if (flip) begin
      a = a - 32'h80000000;
    end
    z = longint'($signed(a));
    x = ROTATOR_GAIN;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    c = clamp_unit(round_away(x, 30 - e2r_pkg::FRAC_BITS));
    s = clamp_unit(round_away(y, 30 - e2r_pkg::FRAC_BITS));
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic e2r_pkg::matrix_t rotation_of(input e2r_pkg::angles_t req);
    longint           sr, cr, sp, cp, sy, cy, srsp, crsp;
    e2r_pkg::matrix_t m;
    angle_sin_cos(req.roll_angle, sr, cr);
    angle_sin_cos(req.pitch_angle, sp, cp);
    angle_sin_cos(req.yaw_angle, sy, cy);
    srsp   = round_away(sr * sp, e2r_pkg::FRAC_BITS);
    crsp   = round_away(cr * sp, e2r_pkg::FRAC_BITS);
    m.xb_x = to_entry(round_away(cp * cy, e2r_pkg::FRAC_BITS));
    m.xb_y = to_entry(round_away(srsp * cy - cr * sy, e2r_pkg::FRAC_BITS));
    m.xb_z = to_entry(round_away(crsp * cy + sr * sy, e2r_pkg::FRAC_BITS));
    m.yb_x = to_entry(round_away(cp * sy, e2r_pkg::FRAC_BITS));
    m.yb_y = to_entry(round_away(srsp * sy + cr * cy, e2r_pkg::FRAC_BITS));
    m.yb_z = to_entry(round_away(crsp * sy - sr * cy, e2r_pkg::FRAC_BITS));
    m.zb_x = to_entry(-sp);
    m.zb_y = to_entry(round_away(sr * cp, e2r_pkg::FRAC_BITS));
    m.zb_z = to_entry(round_away(cr * cp, e2r_pkg::FRAC_BITS));
    return m;
  endfunction

  // ------------------------------------------------------------------ driver

  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (rst) begin
      angles_valid <= 1'b0;
      gap_left     <= 0;
      burst_left   <= $urandom_range(1, 40);
    end else begin
      if (angles_valid && !angles_ready) begin
        input_stall_cycles <= input_stall_cycles + 1;
      end
      if (!angles_valid || angles_ready) begin
        if (angles_valid) begin
          matrix_expected_q.push_back(rotation_of(angles));
          requests_accepted <= requests_accepted + 1;
        end
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          angles_valid <= 1'b0;
        end else if (angles_pending_q.size() > 0) begin
          angles       <= angles_pending_q.pop_front();
          angles_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          angles_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  logic [31:0] ready_pattern = 32'hFFFF_FFFF;
  int          pattern_idx = 0;
  int          hold_left = 0;
  logic [1:0]  hold_done = 2'b00;

  always @(posedge clk) begin
    if (rst) begin
      matrix_ready <= 1'b0;
    end else if (hold_left > 0) begin
      matrix_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done[0] && requests_accepted >= 300) begin
      // hold off long enough for the pipeline to fill and stall its input
      hold_done[0] <= 1'b1;
      hold_left    <= HOLD_OFF_CYCLES;
      matrix_ready <= 1'b0;
    end else if (!hold_done[1] && requests_accepted >= 800) begin
      hold_done[1] <= 1'b1;
      hold_left    <= HOLD_OFF_CYCLES;
      matrix_ready <= 1'b0;
    end else begin
      matrix_ready <= ready_pattern[pattern_idx];
      if (pattern_idx == 31) begin
        pattern_idx <= 0;
        case ($urandom_range(0, 3))
          0: ready_pattern <= 32'hFFFF_FFFF;
          1: ready_pattern <= $urandom;
          2: ready_pattern <= $urandom | $urandom;
          default: ready_pattern <= $urandom & $urandom & $urandom;
        endcase
      end else begin
        pattern_idx <= pattern_idx + 1;
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  task automatic check_entry(input string name,
                             input logic signed [e2r_pkg::FIELD_W-1:0] want,
                             input logic signed [e2r_pkg::FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    e2r_pkg::matrix_t want;
    if (!rst && matrix_valid && matrix_ready) begin
      if (matrix_expected_q.size() == 0) begin
        $error("matrix: result with no request outstanding");
        errors++;
      end else begin
        want = matrix_expected_q.pop_front();
        check_entry("xb_x", want.xb_x, matrix.xb_x);
        check_entry("xb_y", want.xb_y, matrix.xb_y);
        check_entry("xb_z", want.xb_z, matrix.xb_z);
        check_entry("yb_x", want.yb_x, matrix.yb_x);
        check_entry("yb_y", want.yb_y, matrix.yb_y);
        check_entry("yb_z", want.yb_z, matrix.yb_z);
        check_entry("zb_x", want.zb_x, matrix.zb_x);
        check_entry("zb_y", want.zb_y, matrix.zb_y);
        check_entry("zb_z", want.zb_z, matrix.zb_z);
        matrices_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [e2r_pkg::ANGLE_W-1:0] random_angle(input int mode);
    logic signed [e2r_pkg::ANGLE_W-1:0] corners [7];
    corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh4000, -16'sh4000, 16'sh0001,
                -16'sh0001};
    case (mode)
      0, 1, 2, 3, 4, 5: return e2r_pkg::ANGLE_W'($urandom);
      // close to a multiple of an eighth turn, quadrant edges among them
      6, 7: return e2r_pkg::ANGLE_W'($urandom_range(0, 7) * 8192 +
                                     $urandom_range(0, 8) - 4);
      8: return e2r_pkg::ANGLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return corners[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic e2r_pkg::angles_t make_angles(
    input logic signed [e2r_pkg::ANGLE_W-1:0] r,
    input logic signed [e2r_pkg::ANGLE_W-1:0] p,
    input logic signed [e2r_pkg::ANGLE_W-1:0] y
  );
    e2r_pkg::angles_t a;
    a.roll_angle  = r;
    a.pitch_angle = p;
    a.yaw_angle   = y;
    return a;
  endfunction

  initial begin
    int               mode;
    e2r_pkg::angles_t req;

    // zero angles
    angles_pending_q.push_back(make_angles(16'sh0000, 16'sh0000, 16'sh0000));
    angles_pending_q.push_back(make_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    angles_pending_q.push_back(make_angles(16'sh8000, 16'sh8000, 16'sh8000));
    angles_pending_q.push_back(make_angles(16'sh8000, 16'sh0000, 16'sh7FFF));
    // quadrant edges, where the half-plane fold switches
    angles_pending_q.push_back(make_angles(16'sh4000, 16'sh4000, 16'sh4000));
    angles_pending_q.push_back(make_angles(16'sh3FFF, 16'sh3FFF, 16'sh3FFF));
    angles_pending_q.push_back(make_angles(-16'sh4000, -16'sh4000, -16'sh4000));
    angles_pending_q.push_back(make_angles(-16'sh4001, -16'sh4001, -16'sh4001));
    angles_pending_q.push_back(make_angles(16'sh4000, -16'sh4001, 16'sh3FFF));
    // gimbal lock, pitch at +/- a quarter turn
    angles_pending_q.push_back(make_angles(16'sh1234, 16'sh4000, -16'sh2345));
    angles_pending_q.push_back(make_angles(-16'sh1234, -16'sh4000, 16'sh2345));
    // single axis rotations
    angles_pending_q.push_back(make_angles(16'sh2000, 16'sh0000, 16'sh0000));
    angles_pending_q.push_back(make_angles(16'sh0000, 16'sh2000, 16'sh0000));
    angles_pending_q.push_back(make_angles(16'sh0000, 16'sh0000, 16'sh2000));
    angles_pending_q.push_back(make_angles(16'sh0001, -16'sh0001, 16'sh0001));
    angles_pending_q.push_back(make_angles(16'sh5555, 16'shAAAA, 16'sh5555));
    angles_pending_q.push_back(make_angles(16'shAAAA, 16'sh5555, 16'shAAAA));
    angles_pending_q.push_back(make_angles(16'shFFFF, 16'sh0000, 16'shFFFF));
    angles_pending_q.push_back(make_angles(16'sh6000, 16'shE000, 16'shA000));
    angles_pending_q.push_back(make_angles(16'sh2AAB, 16'sh1555, 16'shC000));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      mode = $urandom_range(0, 9);
      req  = make_angles(random_angle(mode), random_angle(mode), random_angle(mode));
      angles_pending_q.push_back(req);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (angles_pending_q.size() > 0 || angles_valid) begin
      @(posedge clk);
    end
    while (matrix_expected_q.size() > 0) begin
      @(posedge clk);
    end
    // let any stray result show up
    repeat (e2r_pkg::LATENCY + 10) @(posedge clk);

    if (matrix_expected_q.size() != 0) begin
      $error("matrix: %0d results never arrived", matrix_expected_q.size());
      errors++;
    end

    $display("Ran %0d angle requests and checked %0d matrices, input held off for %0d cycles.",
             requests_accepted, matrices_checked, input_stall_cycles);
    if (errors == 0) begin
      $display("[euler_to_rotation_matrix_unit] OK");
    end else begin
      $display("[euler_to_rotation_matrix_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Run timed out.");
    $display("[euler_to_rotation_matrix_unit] ERROR");
    $finish;
  end

endmodule
